// ===== rtl/vsqt_pkg.sv =====
// Shared constants, register indexes and the root table builder for the
// vector quantile tracker. No dependencies.
package vsqt_pkg;

    localparam int DEF_VECTOR_DEPTH       = 4096;
    localparam int DEF_STEP_FRACTION_BITS = 24;

    // Register indexes of the configuration channel
    localparam logic [1:0] REG_ALPHA_LEVEL    = 2'd0;
    localparam logic [1:0] REG_MAX_ITERATIONS = 2'd1;
    localparam logic [1:0] REG_VECTOR_LENGTH  = 2'd2;

    localparam logic [15:0] ALPHA_RESET    = 16'd32768;
    localparam logic [20:0] MAX_ITER_RESET = 21'd1000;
    localparam logic [12:0] VEC_LEN_RESET  = 13'd4096;

    // Gamma schedule in Q.24
    localparam logic [23:0] GAMMA_SLOPE = 24'd15099494;
    localparam logic [30:0] GAMMA_BASE  = 31'd1677722;
    localparam logic [30:0] GAMMA_CAP   = 31'h4000_0000;

    localparam int FRAC_ROUNDS = 24;

    typedef logic [31:0] root_tab_t [FRAC_ROUNDS];

    function automatic logic [63:0] int_root(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = 64'd0;
        bit_w = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // Root r[i] = 2^(-2^-(i+1)) in Q0.32
    function automatic root_tab_t build_roots();
        root_tab_t t;
        t[0] = 32'(int_root(64'h8000_0000_0000_0000));
        for (int i = 1; i < FRAC_ROUNDS; i++) begin
            t[i] = 32'(int_root({t[i-1], 32'h0}));
        end
        return t;
    endfunction

endpackage

// ===== rtl/vsqt_step_unit.sv =====
// Step factor unit: works out n^-gamma as 2^(-gamma*log2 n) with sequential
// multiplies and a bit-serial divider. Depends on vsqt_pkg.
module vsqt_step_unit #(
    parameter int STEP_FRACTION_BITS = vsqt_pkg::DEF_STEP_FRACTION_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [31:0]                   pass_n,
    input  logic [20:0]                   span,
    output logic                          done,
    output logic [STEP_FRACTION_BITS-1:0] step
);
    localparam int SFB        = STEP_FRACTION_BITS;
    localparam int SHIFT_BIAS = 32 - SFB;
    localparam logic [32:0] STEP_CAP = 33'((64'd1 << SFB) - 64'd1);
    localparam vsqt_pkg::root_tab_t ROOTS = vsqt_pkg::build_roots();

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MULG  = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_GAM   = 4'd3;
    localparam logic [3:0] S_NORM  = 4'd4;
    localparam logic [3:0] S_SQA   = 4'd5;
    localparam logic [3:0] S_SQB   = 4'd6;
    localparam logic [3:0] S_MULE  = 4'd7;
    localparam logic [3:0] S_SPLIT = 4'd8;
    localparam logic [3:0] S_EXPA  = 4'd9;
    localparam logic [3:0] S_EXPB  = 4'd10;
    localparam logic [3:0] S_SHIFT = 4'd11;

    logic [3:0]     state_reg;
    logic [31:0]    n_reg;
    logic [20:0]    d_reg;
    logic [55:0]    work_reg;
    logic [20:0]    rem_reg;
    logic [5:0]     cnt_reg;
    logic [30:0]    g_reg;
    logic [31:0]    m_reg;
    logic [4:0]     top_reg;
    logic [23:0]    frac_reg;
    logic [63:0]    prod_reg;
    logic [11:0]    k_reg;
    logic [23:0]    f_reg;
    logic [32:0]    r_reg;
    logic [SFB-1:0] step_reg;
    logic           done_reg;

    logic [21:0] trial;
    logic [32:0] sq;
    logic [30:0] g_sum;
    logic [12:0] shamt;
    logic [32:0] shv;

    assign trial = {rem_reg, work_reg[55]};
    assign sq    = prod_reg[63:31];
    assign g_sum = 31'(work_reg[29:0]) + vsqt_pkg::GAMMA_BASE;
    assign shamt = 13'(k_reg) + 13'(SHIFT_BIAS);
    assign shv   = r_reg >> shamt[5:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (start) begin
                        n_reg     <= pass_n;
                        d_reg     <= span - 21'd1;
                        state_reg <= S_MULG;
                    end
                end
                S_MULG: begin
                    work_reg  <= 56'(n_reg - 32'd1) * 56'(vsqt_pkg::GAMMA_SLOPE);
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    if (trial >= {1'b0, d_reg}) begin
                        rem_reg  <= 21'(trial - {1'b0, d_reg});
                        work_reg <= {work_reg[54:0], 1'b1};
                    end else begin
                        rem_reg  <= trial[20:0];
                        work_reg <= {work_reg[54:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd55) begin
                        state_reg <= S_GAM;
                    end
                end
                S_GAM: begin
                    if (work_reg[55:30] != '0 || g_sum > vsqt_pkg::GAMMA_CAP) begin
                        g_reg <= vsqt_pkg::GAMMA_CAP;
                    end else begin
                        g_reg <= g_sum;
                    end
                    m_reg     <= n_reg;
                    top_reg   <= 5'd31;
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    // normalize one bit a cycle; n >= 2 here
                    if (m_reg[31]) begin
                        cnt_reg   <= '0;
                        frac_reg  <= '0;
                        state_reg <= S_SQA;
                    end else begin
                        m_reg   <= {m_reg[30:0], 1'b0};
                        top_reg <= top_reg - 5'd1;
                    end
                end
                S_SQA: begin
                    prod_reg  <= 64'(m_reg) * 64'(m_reg);
                    state_reg <= S_SQB;
                end
                S_SQB: begin
                    if (sq[32]) begin
                        m_reg    <= sq[32:1];
                        frac_reg <= {frac_reg[22:0], 1'b1};
                    end else begin
                        m_reg    <= sq[31:0];
                        frac_reg <= {frac_reg[22:0], 1'b0};
                    end
                    cnt_reg   <= cnt_reg + 6'd1;
                    state_reg <= (cnt_reg == 6'(vsqt_pkg::FRAC_ROUNDS - 1)) ? S_MULE : S_SQA;
                end
                S_MULE: begin
                    prod_reg  <= 64'(g_reg) * 64'({top_reg, frac_reg});
                    state_reg <= S_SPLIT;
                end
                S_SPLIT: begin
                    k_reg     <= prod_reg[59:48];
                    f_reg     <= prod_reg[47:24];
                    r_reg     <= 33'h1_0000_0000;
                    cnt_reg   <= '0;
                    state_reg <= S_EXPA;
                end
                S_EXPA: begin
                    if (f_reg[23]) begin
                        prod_reg  <= 64'(r_reg) * 64'(ROOTS[cnt_reg[4:0]]);
                        state_reg <= S_EXPB;
                    end else begin
                        f_reg     <= {f_reg[22:0], 1'b0};
                        cnt_reg   <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'(vsqt_pkg::FRAC_ROUNDS - 1)) begin
                            state_reg <= S_SHIFT;
                        end
                    end
                end
                S_EXPB: begin
                    r_reg     <= 33'(prod_reg[63:32]);
                    f_reg     <= {f_reg[22:0], 1'b0};
                    cnt_reg   <= cnt_reg + 6'd1;
                    state_reg <= (cnt_reg == 6'(vsqt_pkg::FRAC_ROUNDS - 1)) ? S_SHIFT : S_EXPA;
                end
                S_SHIFT: begin
                    if (shamt >= 13'd40) begin
                        step_reg <= '0;
                    end else if (shv > STEP_CAP) begin
                        step_reg <= SFB'(STEP_CAP);
                    end else begin
                        step_reg <= SFB'(shv);
                    end
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign step = step_reg;

endmodule

// ===== rtl/vector_stochastic_quantile_tracker_core.sv =====
// Top level of the vector quantile tracker: handshake, estimate memory and
// per-element update. Depends on vsqt_pkg and vsqt_step_unit.
//
// Use: samples enter on the s_ channel, one vector element per request, and
// each gives one result on the m_ channel with its position, the updated
// estimate and the pass number; m_tlast marks the last position in use.
// Registers are written over the cfg_ channel; the user writes them only while
// the block is idle, which the block itself does not enforce: index 0
// alpha_level, 1 max_iterations, 2 vector_length. An element goes from request
// through the read, multiply and update states to its result; a new request
// is taken only once the previous element's update is finished. The first
// element of each pass after the first also runs the step unit first: divider,
// normalize, squaring and exponent steps. The step factor is thus worked out
// once per pass and used for the whole vector.
// Reset clears the pass count, position and step factor and loads register
// defaults; the estimate memory is not cleared, pass 1 writes every position in use.
// A stalled receiver holds the finished result in the output register; the
// next element is taken meanwhile and waits in its update step.
module vector_stochastic_quantile_tracker_core #(
    parameter int VECTOR_DEPTH       = vsqt_pkg::DEF_VECTOR_DEPTH,
    parameter int STEP_FRACTION_BITS = vsqt_pkg::DEF_STEP_FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [11:0] position, [43:12] estimate, [75:44] pass_number
    output logic        m_tlast,   // end_of_vector
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data
);
    localparam int SFB    = STEP_FRACTION_BITS;
    localparam int ADDR_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
    localparam logic [12:0] LEN_CAP = 13'((VECTOR_DEPTH < 4096) ? VECTOR_DEPTH : 4096);

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_STEP = 3'd1;
    localparam logic [2:0] T_READ = 3'd2;
    localparam logic [2:0] T_MULT = 3'd3;
    localparam logic [2:0] T_UPD  = 3'd4;

    logic [2:0]        state_reg;
    logic [15:0]       alpha_reg;
    logic [20:0]       max_iter_reg;
    logic [12:0]       vec_len_reg;
    logic [31:0]       pass_reg;
    logic [11:0]       idx_reg;
    logic [SFB-1:0]    step_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic [11:0]       cur_idx_reg;
    logic signed [31:0] sample_reg;
    logic signed [31:0] rd_data_reg;
    logic [16:0]       amt_reg;
    logic              ge_reg;
    logic              m_tvalid_reg;
    logic [79:0]       m_tdata_reg;
    logic              m_tlast_reg;

    logic signed [31:0] mem [VECTOR_DEPTH];

    logic              s_accept;
    logic [31:0]       pass_next;
    logic [12:0]       eff_len;
    logic              last_pos;
    logic [ADDR_W-1:0] slot_next;
    logic [16:0]       factor;
    logic [16+SFB:0]   amt_prod;
    logic signed [32:0] est_wide;
    logic signed [31:0] est_new;
    logic              out_free;
    logic              su_start;
    logic              su_done;
    logic [SFB-1:0]    su_step;
    logic [20:0]       span;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == T_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign pass_next = (idx_reg != 12'd0) ? pass_reg :
                       (pass_reg == 32'hFFFF_FFFF) ? pass_reg : pass_reg + 32'd1;
    assign span      = (max_iter_reg < 21'd2) ? 21'd2 : max_iter_reg;
    assign su_start  = s_accept && (idx_reg == 12'd0) && (pass_next > 32'd1);
    assign slot_next = (32'(idx_reg) < 32'(VECTOR_DEPTH)) ? ADDR_W'(idx_reg)
                                                          : ADDR_W'(VECTOR_DEPTH - 1);

    // Effective length: zero acts as one, clipped to the memory depth and to 4096
    always_comb begin
        eff_len = (vec_len_reg == 13'd0) ? 13'd1 : vec_len_reg;
        if (eff_len > LEN_CAP) begin
            eff_len = LEN_CAP;
        end
    end
    assign last_pos = (13'(cur_idx_reg) + 13'd1 >= eff_len);

    assign factor   = (rd_data_reg >= sample_reg) ? (17'd65536 - 17'(alpha_reg))
                                                  : 17'(alpha_reg);
    assign amt_prod = factor * (17 + SFB)'(step_reg);

    // Pass 1 takes the sample; else add or subtract the step, then saturate to 32 bits
    always_comb begin
        est_wide = ge_reg ? (33'(rd_data_reg) - $signed({16'd0, amt_reg}))
                          : (33'(rd_data_reg) + $signed({16'd0, amt_reg}));
        if (pass_reg <= 32'd1) begin
            est_new = sample_reg;
        end else if (est_wide > 33'sh0_7FFF_FFFF) begin
            est_new = 32'sh7FFF_FFFF;
        end else if (est_wide < -33'sh0_8000_0000) begin
            est_new = 32'sh8000_0000;
        end else begin
            est_new = est_wide[31:0];
        end
    end

    vsqt_step_unit #(
        .STEP_FRACTION_BITS(SFB)
    ) u_step (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (su_start),
        .pass_n (pass_next),
        .span   (span),
        .done   (su_done),
        .step   (su_step)
    );

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= vsqt_pkg::ALPHA_RESET;
            max_iter_reg <= vsqt_pkg::MAX_ITER_RESET;
            vec_len_reg  <= vsqt_pkg::VEC_LEN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vsqt_pkg::REG_ALPHA_LEVEL:    alpha_reg    <= cfg_data[15:0];
                vsqt_pkg::REG_MAX_ITERATIONS: max_iter_reg <= cfg_data;
                vsqt_pkg::REG_VECTOR_LENGTH:  vec_len_reg  <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Estimate memory: registered read, write in the update step
    always_ff @(posedge aclk) begin
        if (state_reg == T_READ) begin
            rd_data_reg <= mem[slot_reg];
        end
        if (state_reg == T_UPD && out_free) begin
            mem[slot_reg] <= est_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == T_IDLE && s_accept) begin
            sample_reg  <= s_tdata;
            slot_reg    <= slot_next;
            cur_idx_reg <= idx_reg;
        end
        if (state_reg == T_MULT) begin
            amt_reg <= amt_prod[16+SFB:SFB];
            ge_reg  <= (rd_data_reg >= sample_reg);
        end
        if (state_reg == T_UPD && out_free) begin
            m_tdata_reg <= {4'd0, pass_reg, est_new, cur_idx_reg};
            m_tlast_reg <= last_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            pass_reg     <= '0;
            idx_reg      <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Raise valid on a finished update, drop it once the receiver takes it
            if (state_reg == T_UPD && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (s_accept) begin
                        pass_reg <= pass_next;
                        if (su_start) begin
                            state_reg <= T_STEP;
                        end else begin
                            if (idx_reg == 12'd0) begin
                                step_reg <= '0;
                            end
                            state_reg <= T_READ;
                        end
                    end
                end
                T_STEP: begin
                    // hold until the step unit finishes
                    if (su_done) begin
                        step_reg  <= su_step;
                        state_reg <= T_READ;
                    end
                end
                T_READ: state_reg <= T_MULT;
                T_MULT: state_reg <= T_UPD;
                T_UPD: begin
                    if (out_free) begin
                        idx_reg      <= last_pos ? 12'd0 : cur_idx_reg + 12'd1;
                        state_reg    <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A result always carries a nonzero pass count
    a_pass_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[75:44] != 32'd0))
        else $error("result with pass count zero");

    // A last-position result wraps the position to zero
    a_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_UPD && out_free && last_pos) |=> (idx_reg == 12'd0))
        else $error("position did not wrap");

    // The step unit is only started from idle on a first element
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        su_start |=> (state_reg == T_STEP))
        else $error("step unit start without step wait");

    // A request is never taken while an earlier one is still at work
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("request taken during work");

endmodule

// ===== tb/vector_stochastic_quantile_tracker_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the vector quantile tracker core: bursty sample
// requests, a stalling receiver and a per-element predictor of the estimates.
// Depends on vsqt_pkg and the core RTL.

module vector_stochastic_quantile_tracker_core_tb;

    typedef struct {
        logic [11:0] position;
        logic [31:0] estimate;
        logic        end_of_vector;
        logic [31:0] pass_number;
    } quantile_result_t;

    // Predictor of the tracker plus the queue of results still to come back.
    class quantile_scoreboard;
        logic [31:0] roots [24];
        logic [31:0] est_mem [4096];
        logic [31:0] passes;
        logic [11:0] position;
        logic [63:0] step;
        logic [15:0] alpha;
        logic [20:0] iters;
        logic [12:0] vlen;
        int written_hi;
        int errors;
        quantile_result_t expected_q[$];

        function new();
            roots[0] = root_floor(64'h8000_0000_0000_0000);
            for (int i = 1; i < 24; i++) roots[i] = root_floor({roots[i-1], 32'h0});
            passes = 0;
            position = 0;
            step = 0;
            alpha = vsqt_pkg::ALPHA_RESET;
            iters = vsqt_pkg::MAX_ITER_RESET;
            vlen = vsqt_pkg::VEC_LEN_RESET;
            written_hi = 0;
            errors = 0;
        endfunction

        // Truncating square root, one result bit per round
        function logic [31:0] root_floor(logic [63:0] v);
            logic [63:0] r;
            logic [63:0] c;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= v) r = c;
            end
            return r[31:0];
        endfunction

        function logic [63:0] log_q24(logic [31:0] n);
            int t;
            logic [63:0] m;
            logic [63:0] frac;
            t = 31;
            while (t > 0 && !n[t]) t--;
            m = 64'(n) << (31 - t);
            frac = 0;
            for (int i = 0; i < 24; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac = frac | 64'd1;
                    m = m >> 1;
                end
            end
            return (64'(t) << 24) | frac;
        endfunction

        // Step factor n^-gamma in Q0.24
        function logic [63:0] step_for(logic [31:0] n);
            logic [63:0] span;
            logic [63:0] g;
            logic [63:0] e;
            logic [63:0] k;
            logic [63:0] f;
            logic [63:0] r;
            logic [63:0] sh;
            span = (iters < 2) ? 64'd2 : 64'(iters);
            g = (64'(n - 1) * 64'(vsqt_pkg::GAMMA_SLOPE)) / (span - 1)
                + 64'(vsqt_pkg::GAMMA_BASE);
            if (g > 64'(vsqt_pkg::GAMMA_CAP)) g = 64'(vsqt_pkg::GAMMA_CAP);
            e = (g * log_q24(n)) >> 24;
            k = e >> 24;
            f = e & 64'hFF_FFFF;
            r = 64'h1_0000_0000;
            for (int i = 0; i < 24; i++)
                if (f[23-i]) r = (r * 64'(roots[i])) >> 32;
            sh = k + 8;
            if (sh >= 40) return 0;
            r = r >> sh;
            if (r > 64'hFF_FFFF) r = 64'hFF_FFFF;
            return r;
        endfunction

        function int eff_length(logic [12:0] l);
            if (l == 0) return 1;
            if (l > 4096) return 4096;
            return int'(l);
        endfunction

        // A new length must never make pass 2+ read an entry never loaded
        function bit length_ok(logic [12:0] l);
            return passes == 0 || (passes == 1 && position != 0)
                || eff_length(l) <= written_hi;
        endfunction

        function void set_reg(logic [1:0] idx, logic [20:0] val);
            case (idx)
                vsqt_pkg::REG_ALPHA_LEVEL:    alpha = val[15:0];
                vsqt_pkg::REG_MAX_ITERATIONS: iters = val;
                vsqt_pkg::REG_VECTOR_LENGTH:  vlen = val[12:0];
                default: ;
            endcase
        endfunction

        function void note_input(logic [31:0] sample);
            longint e;
            longint s;
            bit last;
            quantile_result_t res;
            if (position == 0) begin
                if (passes != 32'hFFFF_FFFF) passes++;
                step = (passes > 1) ? step_for(passes) : 64'd0;
            end
            s = longint'($signed(sample));
            if (passes <= 1) begin
                e = s;
            end else begin
                e = longint'($signed(est_mem[position]));
                if (e >= s) begin
                    e -= longint'(((64'd65536 - 64'(alpha)) * step) >> 24);
                    if (e < -longint'(64'h8000_0000)) e = -longint'(64'h8000_0000);
                end else begin
                    e += longint'((64'(alpha) * step) >> 24);
                    if (e > longint'(64'h7FFF_FFFF)) e = longint'(64'h7FFF_FFFF);
                end
            end
            est_mem[position] = e[31:0];
            if (int'(position) + 1 > written_hi) written_hi = int'(position) + 1;
            last = int'(position) + 1 >= eff_length(vlen);
            res.position = position;
            res.estimate = e[31:0];
            res.end_of_vector = last;
            res.pass_number = passes;
            expected_q.push_back(res);
            position = last ? 12'd0 : position + 12'd1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(logic [11:0] pos, logic [31:0] est, logic eov, logic [31:0] pass_n);
            quantile_result_t x;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result pos %0d", pos));
                return;
            end
            x = expected_q.pop_front();
            if (pos !== x.position)
                report($sformatf("position %0d, want %0d", pos, x.position));
            if (est !== x.estimate)
                report($sformatf("pos %0d estimate %h, want %h", x.position, est, x.estimate));
            if (eov !== x.end_of_vector)
                report($sformatf("pos %0d tlast %b, want %b", x.position, eov,
                                 x.end_of_vector));
            if (pass_n !== x.pass_number)
                report($sformatf("pos %0d pass %0d, want %0d", x.position, pass_n,
                                 x.pass_number));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;       // [31:0] sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;            // [11:0] position, [43:12] estimate, [75:44] pass_number
    logic        m_tlast;            // end_of_vector
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [20:0] cfg_data = '0;

    quantile_scoreboard sb = new();
    int sent = 0;
    int burst_left = 0;
    int results_seen = 0;

    vector_stochastic_quantile_tracker_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // End the run as failed if something hangs
    initial begin
        #30_000_000;
        $display("status: fail");
        $finish;
    end

    // Check every accepted result against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            sb.check(m_tdata[11:0], m_tdata[43:12], m_tlast, m_tdata[75:44]);
        end
    end

    // Receiver: pick a new random stall pattern at intervals; once, hold off for a long
    // stretch so the core fills up and pushes back on the sample requests.
    initial begin
        int cyc;
        int mode;
        int stall_left;
        bit held;
        cyc = 0;
        mode = 0;
        stall_left = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= 300) begin
                held = 1;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 2);
                m_tready <= (mode == 0) ? 1'b1 :
                            (mode == 1) ? 1'($urandom_range(0, 1)) :
                                          ($urandom_range(0, 3) == 0);
            end
            cyc++;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [20:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Offer one sample request; the sender works in bursts with random gaps
    task automatic push_sample(input logic [31:0] x);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(x);
        burst_left--;
        sent++;
    endtask

    // Pause the sender until every result is back, then let the core settle
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_sample();
        logic [31:0] base;
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 70000);
            1: return 32'h8000_0000 + $urandom_range(0, 70000);
            2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            3: begin
                // land close to the stored estimate so both directions occur
                base = sb.est_mem[sb.position];
                return base + 32'($signed($urandom_range(0, 400000)) - 200000);
            end
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int n;
        logic [12:0] len;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pass 1 with an oversized length (acts as 4096); load the extremes.
        write_reg(vsqt_pkg::REG_VECTOR_LENGTH, 21'd8191);
        write_reg(vsqt_pkg::REG_ALPHA_LEVEL, 21'd65535);
        push_sample(32'h7FFF_FFF0);
        push_sample(32'h8000_0005);
        push_sample(32'h0000_0000);
        push_sample(32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++) push_sample($urandom);
        drain();
        // Shrink mid-pass: the current position becomes the last one
        write_reg(vsqt_pkg::REG_VECTOR_LENGTH, 21'd2);
        push_sample(32'h0001_0000);
        drain();
        // Pass 2 saturates upward; pass 3 then steps downward with alpha 0
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        drain();
        write_reg(vsqt_pkg::REG_ALPHA_LEVEL, 21'd0);
        write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'd0);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        drain();
        write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'd1);
        write_reg(vsqt_pkg::REG_VECTOR_LENGTH, 21'd0);
        push_sample(32'h1234_5678);
        push_sample(32'hEDCB_A988);
        drain();

        // Random phases: new settings between phases, random vectors within
        while (sent < 1050) begin
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 3))
                    0: write_reg(vsqt_pkg::REG_ALPHA_LEVEL, 21'd0);
                    1: write_reg(vsqt_pkg::REG_ALPHA_LEVEL, 21'd65535);
                    default: write_reg(vsqt_pkg::REG_ALPHA_LEVEL,
                                       21'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 6))
                    0: write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'($urandom_range(0, 2)));
                    1: write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'd1048576);
                    2: write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'h1F_FFFF);
                    3: write_reg(vsqt_pkg::REG_MAX_ITERATIONS, 21'($urandom));
                    default: write_reg(vsqt_pkg::REG_MAX_ITERATIONS,
                                       21'($urandom_range(2, 50)));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                len = 13'($urandom_range(0, 23));
                if (sb.length_ok(len)) write_reg(vsqt_pkg::REG_VECTOR_LENGTH, 21'(len));
            end
            n = $urandom_range(5, 60);
            for (int i = 0; i < n; i++) push_sample(pick_sample());
            drain();
        end

        if (sb.pending() != 0) sb.report("results missing at end of run");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/vsqt_pkg.sv
rtl/vsqt_step_unit.sv
rtl/vector_stochastic_quantile_tracker_core.sv
tb/vector_stochastic_quantile_tracker_core_tb.sv
